/* rtl/addressable_led_frame_serializer_assert.svh */
// ----------------------------------------------------------------------------
// LED frame serializer assertion macros
// Shared property wrappers, all clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_FRAME_SERIALIZER_ASSERT_SVH
`define ADDRESSABLE_LED_FRAME_SERIALIZER_ASSERT_SVH

// same-cycle implication
`define ALFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/alfs_pkg.sv */
// ----------------------------------------------------------------------------
// LED frame serializer package
// Shared types, codes and sizes for the frame serializer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package alfs_pkg;

	localparam int PIXEL_COUNT    = 256;
	localparam int PIX_AW         = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int WORD_W         = 24;
	localparam int BITS_PER_PIXEL = 24;
	localparam int BIT_AW         = $clog2(BITS_PER_PIXEL + 1);
	localparam int TICK_W         = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

	// input function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_SHOW  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

	localparam logic [7:0]        RST_ONE_HIGH  = 8'd11;
	localparam logic [7:0]        RST_ONE_LOW   = 8'd7;
	localparam logic [7:0]        RST_ZERO_HIGH = 8'd5;
	localparam logic [7:0]        RST_ZERO_LOW  = 8'd12;
	localparam logic [TICK_W-1:0] RST_LATCH     = 16'd480;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_CLEAR,
		OP_WRITE,
		OP_SHOW
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_LATCH
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} out_item_t;

	typedef struct packed {
		op_t               op;
		logic              in_range;
		logic [PIX_AW-1:0] addr;
		logic [WORD_W-1:0] colour;
	} cmd_t;

	typedef struct packed {
		logic              clear;
		logic              wr_en;
		logic [PIX_AW-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic              rd_en;
		logic [PIX_AW-1:0] rd_addr;
	} store_req_t;

endpackage

`default_nettype wire

/* rtl/alfs_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Command queue
// Small register queue between the decode front and the sequencer back.
// ----------------------------------------------------------------------------
`default_nettype none

module alfs_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire alfs_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output alfs_pkg::cmd_t     head,
	output logic               full,
	output logic               empty
);

	alfs_pkg::cmd_t                entry_q [alfs_pkg::FIFO_DEPTH];
	logic [alfs_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [alfs_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [alfs_pkg::FIFO_AW:0]   count_q;

	assign full  = (count_q == (alfs_pkg::FIFO_AW+1)'(alfs_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + alfs_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + alfs_pkg::FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (alfs_pkg::FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (alfs_pkg::FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/alfs_front.sv */
// ----------------------------------------------------------------------------
// Decode front
// Accepts input beats and turns them into queued commands.
// ----------------------------------------------------------------------------
`default_nettype none

module alfs_front (
	input  wire logic               valid,
	input  wire alfs_pkg::in_item_t in_item,
	input  wire logic               fifo_full,
	output logic                    stall,
	output logic                    push,
	output alfs_pkg::cmd_t          cmd
);

	logic [15:0] idx_w;

	assign stall = fifo_full;
	assign push  = valid && !fifo_full;
	assign idx_w = 16'(in_item.pixel_index);

	always_comb begin
		unique case (in_item.func)
			alfs_pkg::FUNC_TICK:  cmd.op = alfs_pkg::OP_TICK;
			alfs_pkg::FUNC_CLEAR: cmd.op = alfs_pkg::OP_CLEAR;
			alfs_pkg::FUNC_WRITE: cmd.op = alfs_pkg::OP_WRITE;
			default:              cmd.op = alfs_pkg::OP_SHOW;
		endcase
		// writes past the end of the store are dropped by the back
		cmd.in_range = (idx_w < 16'(alfs_pkg::PIXEL_COUNT));
		cmd.addr     = idx_w[alfs_pkg::PIX_AW-1:0];
		cmd.colour   = {in_item.green, in_item.red, in_item.blue};
	end

endmodule

`default_nettype wire

/* rtl/alfs_store.sv */
// ----------------------------------------------------------------------------
// Frame store
// One colour word per LED, with per-entry valid bits so a clear is instant.
// ----------------------------------------------------------------------------
`default_nettype none

module alfs_store (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire alfs_pkg::store_req_t         req,
	output logic [alfs_pkg::WORD_W-1:0]       rd_word
);

	logic [alfs_pkg::WORD_W-1:0]      mem [alfs_pkg::PIXEL_COUNT];
	logic [alfs_pkg::PIXEL_COUNT-1:0] vld_q;
	logic [alfs_pkg::WORD_W-1:0]      rd_word_q;
	logic                             rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	// entries never written since the last clear read as black
	assign rd_word = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire

/* rtl/alfs_back.sv */
// ----------------------------------------------------------------------------
// Waveform sequencer
// Executes queued commands, drives the frame store and builds result beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "addressable_led_frame_serializer_assert.svh"

module alfs_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [alfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [alfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire alfs_pkg::cmd_t                    cmd,
	input  wire logic                              fifo_empty,
	output logic                                   pop,
	output alfs_pkg::store_req_t                   store_req,
	input  wire logic [alfs_pkg::WORD_W-1:0]       rd_word,
	output logic                                   valid,
	input  wire logic                              stall,
	output alfs_pkg::out_item_t                    out_item
);

	logic [7:0]                        one_high_q;
	logic [7:0]                        one_low_q;
	logic [7:0]                        zero_high_q;
	logic [7:0]                        zero_low_q;
	logic [alfs_pkg::TICK_W-1:0]       latch_q;

	alfs_pkg::phase_t                  phase_q, phase_d;
	logic [alfs_pkg::PIX_AW-1:0]       pix_q, pix_d;
	logic [alfs_pkg::BIT_AW-1:0]       bit_q, bit_d;
	logic [alfs_pkg::TICK_W-1:0]       tick_q, tick_d;
	logic [alfs_pkg::WORD_W-1:0]       shift_q, shift_d;
	logic                              load_pend_q;

	logic                              out_valid_q;
	alfs_pkg::out_item_t               out_item_q;
	alfs_pkg::out_item_t               res;

	logic                              exec;
	logic                              is_tick;
	logic [alfs_pkg::WORD_W-1:0]       cur_word;
	logic [alfs_pkg::TICK_W-1:0]       tick_inc;
	logic [alfs_pkg::BIT_AW-1:0]       bit_inc;
	logic                              high_done;
	logic                              low_done;
	logic                              latch_done;
	logic                              bit_last;
	logic                              pix_last;

	assign exec    = !fifo_empty && (!out_valid_q || !stall);
	assign pop     = exec;
	assign is_tick = (cmd.op == alfs_pkg::OP_TICK);

	// a freshly read pixel is used straight from the store output
	assign cur_word = load_pend_q ? rd_word : shift_q;

	assign tick_inc   = tick_q + alfs_pkg::TICK_W'(1);
	assign bit_inc    = bit_q + alfs_pkg::BIT_AW'(1);
	assign high_done  = tick_inc >= alfs_pkg::TICK_W'(cur_word[alfs_pkg::WORD_W-1] ?
	                    one_high_q : zero_high_q);
	assign low_done   = tick_inc >= alfs_pkg::TICK_W'(cur_word[alfs_pkg::WORD_W-1] ?
	                    one_low_q : zero_low_q);
	assign latch_done = tick_inc >= latch_q;
	assign bit_last   = bit_inc >= alfs_pkg::BIT_AW'(alfs_pkg::BITS_PER_PIXEL);
	assign pix_last   = pix_q >= alfs_pkg::PIX_AW'(alfs_pkg::PIXEL_COUNT - 1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (exec) begin
			unique case (phase_q)
				alfs_pkg::PH_IDLE: begin
					if (cmd.op == alfs_pkg::OP_SHOW) begin
						phase_d = alfs_pkg::PH_HIGH;
					end
				end
				alfs_pkg::PH_HIGH: begin
					if (is_tick && high_done) begin
						phase_d = alfs_pkg::PH_LOW;
					end
				end
				alfs_pkg::PH_LOW: begin
					if (is_tick && low_done) begin
						phase_d = (bit_last && pix_last) ? alfs_pkg::PH_LATCH :
						          alfs_pkg::PH_HIGH;
					end
				end
				alfs_pkg::PH_LATCH: begin
					if (is_tick && latch_done) begin
						phase_d = alfs_pkg::PH_IDLE;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// counters, store requests and result
	always_comb begin
		pix_d     = pix_q;
		bit_d     = bit_q;
		tick_d    = tick_q;
		shift_d   = cur_word;
		store_req = '0;
		res       = '0;
		if (exec) begin
			unique case (phase_q)
				alfs_pkg::PH_IDLE: begin
					unique case (cmd.op)
						alfs_pkg::OP_CLEAR: store_req.clear = 1'b1;
						alfs_pkg::OP_WRITE: begin
							store_req.wr_en   = cmd.in_range;
							store_req.wr_addr = cmd.addr;
							store_req.wr_data = cmd.colour;
						end
						alfs_pkg::OP_SHOW: begin
							store_req.rd_en   = 1'b1;
							store_req.rd_addr = '0;
							pix_d             = '0;
							bit_d             = '0;
							tick_d            = '0;
							res.busy_res      = 1'b1;
						end
						default: res = '0;
					endcase
				end
				alfs_pkg::PH_HIGH: begin
					res.busy_res   = 1'b1;
					res.line_level = 1'b1;
					if (is_tick) begin
						tick_d = high_done ? '0 : tick_inc;
					end
				end
				alfs_pkg::PH_LOW: begin
					res.busy_res = 1'b1;
					if (is_tick) begin
						tick_d = tick_inc;
						if (low_done) begin
							tick_d  = '0;
							shift_d = {cur_word[alfs_pkg::WORD_W-2:0], 1'b0};
							bit_d   = bit_inc;
							if (bit_last) begin
								bit_d = '0;
								if (!pix_last) begin
									pix_d             = pix_q + alfs_pkg::PIX_AW'(1);
									store_req.rd_en   = 1'b1;
									store_req.rd_addr = pix_q + alfs_pkg::PIX_AW'(1);
								end
							end
						end
					end
				end
				alfs_pkg::PH_LATCH: begin
					res.busy_res = 1'b1;
					if (is_tick) begin
						tick_d = tick_inc;
						if (latch_done) begin
							res.frame_done = 1'b1;
							tick_d         = '0;
							pix_d          = '0;
							bit_d          = '0;
						end
					end
				end
				default: res = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q  <= alfs_pkg::RST_ONE_HIGH;
			one_low_q   <= alfs_pkg::RST_ONE_LOW;
			zero_high_q <= alfs_pkg::RST_ZERO_HIGH;
			zero_low_q  <= alfs_pkg::RST_ZERO_LOW;
			latch_q     <= alfs_pkg::RST_LATCH;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				alfs_pkg::CFG_ONE_HIGH:  one_high_q  <= cfg_wdata[7:0];
				alfs_pkg::CFG_ONE_LOW:   one_low_q   <= cfg_wdata[7:0];
				alfs_pkg::CFG_ZERO_HIGH: zero_high_q <= cfg_wdata[7:0];
				alfs_pkg::CFG_ZERO_LOW:  zero_low_q  <= cfg_wdata[7:0];
				alfs_pkg::CFG_LATCH:     latch_q     <= cfg_wdata;
				default:                 latch_q     <= latch_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= alfs_pkg::PH_IDLE;
			pix_q       <= '0;
			bit_q       <= '0;
			tick_q      <= '0;
			shift_q     <= '0;
			load_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			pix_q       <= pix_d;
			bit_q       <= bit_d;
			tick_q      <= tick_d;
			shift_q     <= shift_d;
			load_pend_q <= store_req.rd_en;
			if (!out_valid_q || !stall) begin
				out_valid_q <= exec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_item_q <= res;
		end
	end

	assign valid    = out_valid_q;
	assign out_item = out_item_q;

	`ALFS_ASSERT_NEXT(a_show_reads_store,
		exec && phase_q == alfs_pkg::PH_IDLE && cmd.op == alfs_pkg::OP_SHOW,
		load_pend_q && phase_q == alfs_pkg::PH_HIGH, "show did not start a pixel read")
	`ALFS_ASSERT_NOW(a_idle_counters_clear, phase_q == alfs_pkg::PH_IDLE,
		bit_q == '0 && tick_q == '0 && pix_q == '0, "counters left dirty while idle")
	`ALFS_ASSERT_NEXT(a_busy_cmd_holds,
		exec && phase_q != alfs_pkg::PH_IDLE && !is_tick,
		phase_q == $past(phase_q) && tick_q == $past(tick_q), "busy command moved the waveform")
	`ALFS_ASSERT_NOW(a_bit_in_range, 1'b1,
		bit_q < alfs_pkg::BIT_AW'(alfs_pkg::BITS_PER_PIXEL), "bit counter ran past a pixel")

endmodule

`default_nettype wire

/* rtl/addressable_led_frame_serializer.sv */
// ----------------------------------------------------------------------------
// Addressable LED frame serializer
// Frame store plus pulse-width line encoder for a chain of RGB LEDs.
// ----------------------------------------------------------------------------
// Input beats carry func (tick, clear frame, write pixel, start show) with a
// pixel index and colour; each accepted beat gives exactly one result beat
// with the line level, busy flag and frame-done flag for that beat.
// A show streams every pixel as green, red, blue, MSB first; each bit is a
// high then a low pulse whose lengths in tick beats come from the timing
// registers, and a low latch period ends the frame. Only tick beats move the
// waveform; clear, write and show are ignored while busy.
// Timing registers are written through cfg_wr_en / cfg_index / cfg_wdata;
// the user must write them only while no beat is in flight, which the block
// itself does not enforce. The new value is used from the next compare.
// Each input beat passes through a four-entry command queue, one sequencer
// step and the output register; one beat is taken per cycle while in_stall
// is low. Reset clears the frame store at once through per-pixel valid bits,
// so the block accepts beats straight after reset.
// When the result side stalls the output register holds, the queue fills and
// stall is raised towards the input once it holds four beats.
// ----------------------------------------------------------------------------
`default_nettype none

module addressable_led_frame_serializer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [alfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [alfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire alfs_pkg::in_item_t                in_item,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output alfs_pkg::out_item_t                    out_item
);

	alfs_pkg::cmd_t        push_cmd;
	alfs_pkg::cmd_t        head_cmd;
	alfs_pkg::store_req_t  store_req;
	logic                  push;
	logic                  pop;
	logic                  fifo_full;
	logic                  fifo_empty;
	logic [alfs_pkg::WORD_W-1:0] rd_word;

	alfs_front u_front (
		.valid     (in_valid),
		.in_item   (in_item),
		.fifo_full (fifo_full),
		.stall     (in_stall),
		.push      (push),
		.cmd       (push_cmd)
	);

	alfs_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head_cmd),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	alfs_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_word (rd_word)
	);

	alfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (head_cmd),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.store_req  (store_req),
		.rd_word    (rd_word),
		.valid      (out_valid),
		.stall      (out_stall),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire
